FILE: design/cst_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the comment stripping tokenizer.
package cst_pkg;

  localparam int LINE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int PUSH_MAX      = 3;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_HASH  = 2'd1;
  localparam logic [1:0] MODE_SLASH = 2'd2;

  localparam logic [1:0] REG_DELIM_LOW  = 2'd0;
  localparam logic [1:0] REG_DELIM_HIGH = 2'd1;
  localparam logic [1:0] REG_MODE       = 2'd2;

  typedef enum logic [3:0] {
    CS_OUT   = 4'b0001,
    CS_LINE  = 4'b0010,
    CS_BLOCK = 4'b0100,
    CS_OPEN  = 4'b1000
  } cst_cstate_t;

  typedef struct packed {
    cst_cstate_t cstate;
    logic        star_seen;
    logic        inside_word;
  } cst_scan_t;

  localparam cst_scan_t SCAN_RESET = '{cstate: CS_OUT, star_seen: 1'b0, inside_word: 1'b0};

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
  } cst_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        starts_token;
    logic [15:0] line_number;
    logic        stream_done;
  } cst_out_t;

endpackage

FILE: design/cst_proc.sv
`timescale 1ns / 1ps
// One byte through the comment filter and the tokenizer.
module cst_proc #(
  parameter int LINE_BITS = cst_pkg::LINE_BITS_DEF
) (
  input  logic [1:0]             mode,
  input  logic [63:0]            delim_low,
  input  logic [63:0]            delim_high,
  input  cst_pkg::cst_scan_t     scan_in,
  input  logic [LINE_BITS-1:0]   line_in,
  input  logic [7:0]             c,
  input  logic                   la_valid,
  input  logic [7:0]             la,
  output cst_pkg::cst_scan_t     scan_out,
  output logic [LINE_BITS-1:0]   line_out,
  output logic                   emit,
  output cst_pkg::cst_out_t      res
);
  import cst_pkg::*;

  logic [7:0]  o;
  cst_cstate_t cstate_n;
  logic        star_n;
  logic        is_delim;
  logic        is_ws;
  logic        is_lf;
  logic [31:0] line_ext;

  // comment filter
  always_comb begin
    o        = c;
    cstate_n = scan_in.cstate;
    star_n   = scan_in.star_seen;
    if (mode == MODE_HASH || mode == MODE_SLASH) begin
      case (scan_in.cstate)
        CS_OUT: begin
          if (mode == MODE_HASH && c == CH_HASH) begin
            cstate_n = CS_LINE;
          end else if (c == CH_SLASH && la_valid && la == CH_SLASH) begin
            cstate_n = CS_LINE;
          end else if (c == CH_SLASH && la_valid && la == CH_STAR) begin
            cstate_n = CS_OPEN;
          end
          if (cstate_n != CS_OUT) o = CH_SPACE;
        end
        CS_LINE: begin
          if (c == CH_LF) begin
            cstate_n = CS_OUT;
            if (mode == MODE_SLASH) o = CH_SPACE;
          end else begin
            o = CH_SPACE;
          end
        end
        CS_OPEN: begin
          // second byte of the opening pair
          o        = CH_SPACE;
          cstate_n = CS_BLOCK;
          star_n   = 1'b0;
        end
        CS_BLOCK: begin
          o = CH_SPACE;
          if (scan_in.star_seen && c == CH_SLASH) begin
            cstate_n = CS_OUT;
            star_n   = 1'b0;
          end else begin
            star_n = (c == CH_STAR);
          end
        end
        default: begin
          cstate_n = CS_OUT;
          star_n   = 1'b0;
        end
      endcase
    end else begin
      cstate_n = CS_OUT;
      star_n   = 1'b0;
    end
  end

  // tokenizer
  assign is_delim = !o[7] && (o[6] ? delim_high[o[5:0]] : delim_low[o[5:0]]);
  assign is_lf    = (o == CH_LF);
  assign is_ws    = o inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
  assign emit     = is_delim || !is_ws;

  assign scan_out = '{cstate: cstate_n, star_seen: star_n,
                      inside_word: !is_delim && !is_ws};

  assign line_out = (is_lf && line_in != '1) ? line_in + LINE_BITS'(1) : line_in;
  assign line_ext = 32'(line_in);

  assign res = '{out_byte: o,
                 starts_token: is_delim || !scan_in.inside_word,
                 line_number: line_ext[15:0],
                 stream_done: 1'b0};

endmodule

FILE: design/cst_queue.sv
`timescale 1ns / 1ps
// Result queue: takes up to three beats a cycle, drains one from its head.
module cst_queue (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [cst_pkg::PUSH_MAX-1:0]         push,
  input  cst_pkg::cst_out_t [cst_pkg::PUSH_MAX-1:0] push_data,
  output logic                                 room,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output cst_pkg::cst_out_t                    out_data
);
  import cst_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cst_out_t [QUEUE_DEPTH-1:0] entry;
  cst_out_t [QUEUE_DEPTH-1:0] entry_next;
  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic [CW-1:0]              base;
  logic [CW-1:0]              pos [PUSH_MAX];
  logic                       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = entry[0];
  assign room      = (count <= CW'(QUEUE_DEPTH - PUSH_MAX));

  always_comb begin
    base   = count - CW'(pop);
    pos[0] = base;
    for (int k = 1; k < PUSH_MAX; k++) begin
      pos[k] = pos[k-1] + CW'(push[k-1]);
    end
    count_next = pos[PUSH_MAX-1] + CW'(push[PUSH_MAX-1]);
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      if (pop && j < QUEUE_DEPTH - 1) entry_next[j] = entry[(j + 1) % QUEUE_DEPTH];
      else entry_next[j] = entry[j];
      for (int k = 0; k < PUSH_MAX; k++) begin
        if (push[k] && pos[k] == CW'(j)) entry_next[j] = push_data[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

FILE: design/comment_strip_tokenizer_top.sv
`timescale 1ns / 1ps
// Top level of the comment stripping tokenizer.
// Results: a byte is pushed to the result queue when the beat that brings its
// lookahead is taken; a last beat's results (held byte, last byte, done marker)
// are pushed together and leave from the queue head in that order. Throughput:
// one beat per cycle while the queue has room; a last beat with three results
// stalls the input while the queue drains. Reset: synchronous; clears stream
// state and the queue, delimiters to zero, comment mode to hash.
module comment_strip_tokenizer_top #(
  parameter int LINE_BITS = cst_pkg::LINE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cst_pkg::cst_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cst_pkg::cst_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import cst_pkg::*;

  // configuration registers
  logic [63:0] delim_low;
  logic [63:0] delim_high;
  logic [1:0]  comment_mode;

  // running stream state
  logic [7:0]           held_byte;
  logic                 held_valid;
  cst_scan_t            scan;
  logic [LINE_BITS-1:0] line_count;

  // first pass: the held byte, with the new byte as lookahead
  cst_scan_t            scan_a;
  logic [LINE_BITS-1:0] line_a;
  logic                 emit_a;
  cst_out_t             res_a;
  cst_scan_t            scan_mid;
  logic [LINE_BITS-1:0] line_mid;

  // second pass: the new byte itself, only used on a last beat
  cst_scan_t            scan_b;
  logic [LINE_BITS-1:0] line_b;
  logic                 emit_b;
  cst_out_t             res_b;
  logic [31:0]          line_done;

  logic                        take;
  logic                        room;
  logic [PUSH_MAX-1:0]         push;
  cst_out_t [PUSH_MAX-1:0]     push_data;

  assign in_ready = room;
  assign take     = in_valid && in_ready;

  cst_proc #(.LINE_BITS(LINE_BITS)) u_proc_held (
    .mode       (comment_mode),
    .delim_low  (delim_low),
    .delim_high (delim_high),
    .scan_in    (scan),
    .line_in    (line_count),
    .c          (held_byte),
    .la_valid   (1'b1),
    .la         (in_data.text_byte),
    .scan_out   (scan_a),
    .line_out   (line_a),
    .emit       (emit_a),
    .res        (res_a)
  );

  assign scan_mid = held_valid ? scan_a : scan;
  assign line_mid = held_valid ? line_a : line_count;

  // last byte has no lookahead, so it can't open a slash comment
  cst_proc #(.LINE_BITS(LINE_BITS)) u_proc_last (
    .mode       (comment_mode),
    .delim_low  (delim_low),
    .delim_high (delim_high),
    .scan_in    (scan_mid),
    .line_in    (line_mid),
    .c          (in_data.text_byte),
    .la_valid   (1'b0),
    .la         (8'h00),
    .scan_out   (scan_b),
    .line_out   (line_b),
    .emit       (emit_b),
    .res        (res_b)
  );

  assign line_done = 32'(line_b);

  // results in stream order: held byte, last byte, done marker
  assign push[0] = take && held_valid && emit_a;
  assign push[1] = take && in_data.is_last && emit_b;
  assign push[2] = take && in_data.is_last;
  assign push_data[0] = res_a;
  assign push_data[1] = res_b;
  assign push_data[2] = '{out_byte: 8'h00, starts_token: 1'b0,
                          line_number: line_done[15:0], stream_done: 1'b1};

  cst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_low    <= '0;
      delim_high   <= '0;
      comment_mode <= MODE_HASH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELIM_LOW:  delim_low    <= cfg_data;
        REG_DELIM_HIGH: delim_high   <= cfg_data;
        REG_MODE:       comment_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte  <= '0;
      held_valid <= 1'b0;
      scan       <= SCAN_RESET;
      line_count <= '0;
    end else if (take) begin
      if (in_data.is_last) begin
        // stream ends: back to a fresh start
        held_byte  <= '0;
        held_valid <= 1'b0;
        scan       <= SCAN_RESET;
        line_count <= '0;
      end else begin
        held_byte  <= in_data.text_byte;
        held_valid <= 1'b1;
        scan       <= scan_mid;
        line_count <= line_mid;
      end
    end
  end

endmodule
